FILE: sv/u16to8_pkg.sv
// Shared types, constants and UTF-8 helper functions for the UTF-16LE to UTF-8 transcoder.
// Depends on nothing; every module of the transcoder uses it by scoped names.
`default_nettype none

package u16to8_pkg;

  // Upper six bits of a surrogate unit.
  localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;  // D800..DBFF
  localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;  // DC00..DFFF
  localparam logic [15:0] BOM_UNIT      = 16'hFEFF;
  localparam logic [20:0] PLANE1_BASE   = 21'h10000;

  // Work handed from the front end to the byte sequencer: up to two code
  // points, sent in order (slot 0 first).
  typedef struct packed {
    logic [20:0] cp0;
    logic        has0;
    logic [15:0] cp1;
    logic        has1;
  } job_t;

  // Encoded length of a code point minus one (0 means one byte).
  function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
    logic [1:0] lm1;
    if (cp < 21'h80) begin
      lm1 = 2'd0;
    end else if (cp < 21'h800) begin
      lm1 = 2'd1;
    end else if (cp < 21'h10000) begin
      lm1 = 2'd2;
    end else begin
      lm1 = 2'd3;
    end
    return lm1;
  endfunction

  // Byte number idx of the UTF-8 form of cp, whose length minus one is lm1.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] lm1,
                                           input logic [1:0] idx);
    logic [1:0] k;
    logic [5:0] cont;
    logic [7:0] b;
    k = lm1 - idx;
    unique case (k)
      2'd0: cont = cp[5:0];
      2'd1: cont = cp[11:6];
      2'd2: cont = cp[17:12];
      2'd3: cont = {3'b000, cp[20:18]};
    endcase
    if (idx == 2'd0) begin
      unique case (lm1)
        2'd0: b = {1'b0, cp[6:0]};
        2'd1: b = {3'b110, cp[10:6]};
        2'd2: b = {4'b1110, cp[15:12]};
        2'd3: b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      b = {2'b10, cont};
    end
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: sv/utf16le_to_utf8_transcoder_unit.sv
// UTF-16LE to UTF-8 transcoder, top level.
// Instantiates u16to8_front, u16to8_queue and u16to8_back; uses u16to8_pkg.
//
// Usage: the input channel (in_valid/in_ready, in_byte, in_end_of_stream)
// carries the UTF-16LE stream one byte per transfer, low byte of each unit
// first. in_end_of_stream marks the final byte; after it a held high
// surrogate is sent and the block is back in its start state, so a leading
// FF FE mark of the next stream is dropped again. The result channel
// (out_valid/out_ready, out_byte, out_run_last) carries the UTF-8 bytes one
// per transfer; out_run_last is high on the last byte caused by an input byte.
// Input bytes that cause no output produce no transfer at all.
//
// Throughput: an input byte is taken in every cycle while the job queue has
// room; the output side sends one byte per cycle while the receiver takes
// them, so the sustained rate is set by the single-byte result channel: an
// input byte costs as many output transfers as the UTF-8 bytes it causes (0
// to 6). The first byte of a job passes through the queue, the sequencer's
// job register and the output register before it appears on out_byte.
//
// Reset (rst_n low, synchronous) empties the queue and the output stage and
// returns the pairing state to the start of a stream. When the receiver
// stalls, the output register holds its byte, the sequencer waits and the
// queue fills; in_ready drops only once QUEUE_DEPTH jobs are waiting.
`default_nettype none

module utf16le_to_utf8_transcoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_stream,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_run_last
);

  // Jobs from the front end: up to two code points for each input byte.
  u16to8_pkg::job_t push_job;
  u16to8_pkg::job_t pop_job;
  logic             push, push_ready;
  logic             pop, pop_valid;

  u16to8_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_ready          (push_ready),
    .q_push           (push),
    .q_job            (push_job)
  );

  // The queue lets the front end keep taking bytes while the output stalls.
  u16to8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job)
  );

  u16to8_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (pop_valid),
    .q_job        (pop_job),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule

`default_nettype wire

FILE: sv/u16to8_front.sv
// Front end: pairs input bytes into UTF-16 units, tracks surrogates and the mark,
// and turns each input byte into a job of up to two code points. Uses u16to8_pkg.
`default_nettype none

module u16to8_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_end_of_stream,
  input  wire logic              q_ready,
  output logic                   q_push,
  output u16to8_pkg::job_t       q_job
);

  logic       odd_r, odd_nxt;
  logic [7:0] held_r, held_nxt;
  logic       hw_r, hw_nxt;
  logic [9:0] hb_r, hb_nxt;
  logic       start_r, start_nxt;

  logic        accept;
  logic [15:0] unit;
  logic        unit_done, is_mark, unit_high, unit_low, handled;
  logic        pair, flush_pre, unit_emit, eos_flush;
  logic        new_hw;
  logic [9:0]  new_hb;

  assign in_ready  = q_ready;
  assign accept    = in_valid && in_ready;
  assign unit      = {in_byte, held_r};
  assign unit_done = odd_r;
  assign is_mark   = start_r && (unit == u16to8_pkg::BOM_UNIT);
  assign unit_high = (unit[15:10] == u16to8_pkg::SURR_HIGH_TAG);
  assign unit_low  = (unit[15:10] == u16to8_pkg::SURR_LOW_TAG);
  assign handled   = unit_done && !is_mark;

  assign pair      = handled && hw_r && unit_low;
  assign flush_pre = handled && hw_r && !unit_low;
  assign unit_emit = handled && !pair && !unit_high;
  assign new_hw    = handled ? unit_high : hw_r;
  assign new_hb    = handled ? (unit_high ? unit[9:0] : 10'd0) : hb_r;
  assign eos_flush = in_end_of_stream && new_hw;

  always_comb begin
    q_job.has0 = pair || flush_pre;
    q_job.cp0  = pair ? (u16to8_pkg::PLANE1_BASE + {1'b0, hb_r, unit[9:0]})
                      : {5'b00000, u16to8_pkg::SURR_HIGH_TAG, hb_r};
    q_job.has1 = unit_emit || eos_flush;
    q_job.cp1  = unit_emit ? unit : {u16to8_pkg::SURR_HIGH_TAG, new_hb};
  end

  assign q_push = accept && (q_job.has0 || q_job.has1);

  always_comb begin
    odd_nxt   = odd_r;
    held_nxt  = held_r;
    hw_nxt    = hw_r;
    hb_nxt    = hb_r;
    start_nxt = start_r;
    if (accept) begin
      if (in_end_of_stream) begin
        odd_nxt   = 1'b0;
        held_nxt  = 8'd0;
        hw_nxt    = 1'b0;
        hb_nxt    = 10'd0;
        start_nxt = 1'b1;
      end else if (!odd_r) begin
        odd_nxt  = 1'b1;
        held_nxt = in_byte;
      end else begin
        odd_nxt   = 1'b0;
        held_nxt  = 8'd0;
        start_nxt = 1'b0;
        hw_nxt    = new_hw;
        hb_nxt    = new_hb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odd_r   <= 1'b0;
      held_r  <= 8'd0;
      hw_r    <= 1'b0;
      hb_r    <= 10'd0;
      start_r <= 1'b1;
    end else begin
      odd_r   <= odd_nxt;
      held_r  <= held_nxt;
      hw_r    <= hw_nxt;
      hb_r    <= hb_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/u16to8_queue.sv
// Small job queue between the front end and the byte sequencer.
// Holds u16to8_pkg::job_t entries; depth set by a parameter.
`default_nettype none

module u16to8_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire u16to8_pkg::job_t push_job,
  output logic                  push_ready,
  input  wire logic             pop,
  output logic                  pop_valid,
  output u16to8_pkg::job_t      pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u16to8_pkg::job_t entries [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = entries[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/u16to8_back.sv
// Byte sequencer: takes jobs from the queue and sends their UTF-8 bytes one per
// cycle while the receiver takes them, through a registered output stage. Uses u16to8_pkg.
`default_nettype none

module u16to8_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire u16to8_pkg::job_t q_job,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_run_last
);

  logic             busy_r;
  u16to8_pkg::job_t job_r;
  logic             slot_r;
  logic [1:0]       idx_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic [20:0] cur_cp;
  logic [1:0]  lm1;
  logic        can_emit, step, slot_end, job_end;

  assign cur_cp   = slot_r ? {5'b00000, job_r.cp1} : job_r.cp0;
  assign lm1      = u16to8_pkg::utf8_len_m1(cur_cp);
  assign can_emit = !out_valid_r || out_ready;
  assign step     = busy_r && can_emit;
  assign slot_end = (idx_r == lm1);
  assign job_end  = slot_end && (slot_r || !job_r.has1);
  assign q_pop    = q_valid && (!busy_r || (step && job_end));

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slot_r      <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        slot_r <= !q_job.has0;
        idx_r  <= 2'd0;
      end else if (step && job_end) begin
        busy_r <= 1'b0;
      end else if (step) begin
        if (slot_end) begin
          slot_r <= 1'b1;
          idx_r  <= 2'd0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (step) begin
      out_byte_r <= u16to8_pkg::utf8_byte(cur_cp, lm1, idx_r);
      out_last_r <= job_end;
    end
  end

endmodule

`default_nettype wire

FILE: verif/utf16le_to_utf8_transcoder_unit_tb.sv
// Self-checking bench for the UTF-16LE to UTF-8 transcoder: directed byte streams,
// then random streams with bursty input and a stalling receiver. Needs the RTL of
// utf16le_to_utf8_transcoder_unit, its submodules and its package.
`timescale 1ns / 1ps

module utf16le_to_utf8_transcoder_unit_tb;

  localparam int LIMIT_CYCLES = 200000;  // generous guard against a hung handshake
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 16;      // settling margin after the last expected byte
  localparam int LONG_HOLD = 80;         // long enough to fill the job queue
  localparam int ITEMS_TARGET = 480;
  localparam int HOLD_AT_ITEM = 150;
  localparam int DRAIN_AT_ITEM = 320;

  localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_SURR_LAST = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_FIRST = 16'hDC00;
  localparam logic [15:0] LOW_SURR_LAST = 16'hDFFF;
  localparam logic [15:0] MARK_UNIT = 16'hFEFF;

  // Receiver stall patterns; each one runs for a segment of random length.
  typedef enum int {RX_FULL, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

  // Kinds of UTF-16 content that the random streams are built from.
  typedef enum int {
    U_ASCII, U_TWO, U_THREE, U_PAIR, U_LONE_HIGH, U_LONE_LOW, U_MARK, U_ANY
  } unit_kind_t;

  // One expected UTF-8 byte together with its run_last flag.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_beat_t;

  // Tracks the pairing and surrogate state of the stream and keeps the UTF-8
  // bytes still owed by the block, oldest first.
  class utf8_tracker;
    bit          odd_phase;
    logic [7:0]  held_low;
    bit          high_waiting;
    logic [9:0]  high_bits;
    bit          at_start;
    utf8_beat_t  owed_utf8[$];
    utf8_beat_t  step_utf8[$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      odd_phase = 0;
      held_low = '0;
      high_waiting = 0;
      high_bits = '0;
      at_start = 1;
    endfunction

    function void add_byte(logic [7:0] b);
      utf8_beat_t beat;
      beat.data = b;
      beat.last = 1'b0;
      step_utf8.insert(step_utf8.size(), beat);
    endfunction

    function void encode(logic [20:0] cp);
      if (cp < 21'h80) begin
        add_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end else begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endfunction

    // A held high surrogate that finds no partner goes out on its own.
    function void flush_high();
      if (high_waiting) begin
        encode({5'd0, HIGH_SURR_FIRST[15:10], high_bits});
        high_waiting = 0;
        high_bits = '0;
      end
    endfunction

    function void take_unit(logic [15:0] unit);
      if (high_waiting && unit >= LOW_SURR_FIRST && unit <= LOW_SURR_LAST) begin
        encode(21'h10000 + {1'b0, high_bits, unit[9:0]});
        high_waiting = 0;
        high_bits = '0;
      end else begin
        flush_high();
        if (unit >= HIGH_SURR_FIRST && unit <= HIGH_SURR_LAST) begin
          high_waiting = 1;
          high_bits = unit[9:0];
        end else begin
          encode({5'd0, unit});
        end
      end
    endfunction

    // Called once per accepted input transfer.
    function void take_utf16_byte(logic [7:0] b, logic eos);
      logic [15:0] unit;
      step_utf8.delete();
      if (!odd_phase) begin
        held_low = b;
        odd_phase = 1;
      end else begin
        unit = {b, held_low};
        odd_phase = 0;
        held_low = '0;
        // Only the very first unit of a stream can be a dropped mark.
        if (!(at_start && unit == MARK_UNIT)) begin
          at_start = 0;
          take_unit(unit);
        end
        at_start = 0;
      end
      if (eos) begin
        flush_high();
        restart();
      end
      if (step_utf8.size() > 0) begin
        step_utf8[step_utf8.size() - 1].last = 1'b1;
      end
      foreach (step_utf8[i]) begin
        owed_utf8.insert(owed_utf8.size(), step_utf8[i]);
      end
    endfunction

    // Called once per accepted output transfer.
    function void match_utf8_byte(logic [7:0] b, logic last);
      utf8_beat_t want;
      if (owed_utf8.size() == 0) begin
        $display("%0t: unexpected output byte %02h run_last %0b", $time, b, last);
        errors++;
      end else begin
        want = owed_utf8.pop_front();
        if (b !== want.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data, b);
          errors++;
        end
        if (last !== want.last) begin
          $display("%0t: out_run_last expected %0b actual %0b", $time, want.last, last);
          errors++;
        end
      end
    endfunction

    function int owed_count();
      return owed_utf8.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;

  utf8_tracker board;
  bit          hold_request = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  logic [7:0]  stream_bytes[$];

  utf16le_to_utf8_transcoder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last)
  );

  always #2 clk = ~clk;

  // Run guard: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Output monitor. Sampling at the edge sees the values from before the edge,
  // so every accepted result transfer is checked exactly once.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.match_utf8_byte(out_byte, out_run_last);
    end
  end

  // Receiver. It switches between stall patterns, including stretches with no
  // stall at all, and on request holds off long enough that the
  // job queue fills and in_ready drops while the sender keeps offering bytes.
  initial begin : receiver
    int          seg_left;
    int          hold_left;
    int          tick;
    rx_pattern_t pattern;
    seg_left = 0;
    hold_left = 0;
    tick = 0;
    pattern = RX_FULL;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 0;
        hold_left = LONG_HOLD;
      end
      if (seg_left == 0) begin
        pattern = rx_pattern_t'($urandom_range(0, 3));
        seg_left = $urandom_range(8, 40);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (pattern)
          RX_FULL:     out_ready <= 1'b1;
          RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_ready <= (tick % 3 != 0);
          default:     out_ready <= 1'b1;
        endcase
      end
    end
  end

  // Offers one byte and returns once it has been accepted. The sender works in
  // bursts; between most bursts valid drops for a random gap. Valid is
  // left high after a transfer so back-to-back bytes need no extra assignment.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_utf16_byte(b, eos);
    items_sent++;
  endtask

  // Sends the collected stream; end_of_stream goes on its final byte if asked.
  task automatic send_stream(input bit with_end);
    foreach (stream_bytes[i]) begin
      send_byte(stream_bytes[i], with_end && (i == stream_bytes.size() - 1));
    end
    stream_bytes.delete();
  endtask

  function automatic void append_byte(logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
  endfunction

  function automatic void push_unit(logic [15:0] u);
    append_byte(u[7:0]);
    append_byte(u[15:8]);
  endfunction

  function automatic void push_random_unit();
    unit_kind_t kind;
    kind = unit_kind_t'($urandom_range(0, 7));
    case (kind)
      U_ASCII: push_unit(16'($urandom_range(0, 16'h7F)));
      U_TWO:   push_unit(16'($urandom_range(16'h80, 16'h7FF)));
      U_THREE: begin
        if ($urandom_range(0, 1)) push_unit(16'($urandom_range(16'h800, 16'hD7FF)));
        else push_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
      end
      U_PAIR: begin
        push_unit(HIGH_SURR_FIRST + 16'($urandom_range(0, 1023)));
        push_unit(LOW_SURR_FIRST + 16'($urandom_range(0, 1023)));
      end
      U_LONE_HIGH: push_unit(HIGH_SURR_FIRST + 16'($urandom_range(0, 1023)));
      U_LONE_LOW:  push_unit(LOW_SURR_FIRST + 16'($urandom_range(0, 1023)));
      U_MARK:      push_unit(MARK_UNIT);
      default:     push_unit(16'($urandom_range(0, 16'hFFFF)));
    endcase
  endfunction

  // Most streams are well formed: an optional leading mark, then a mix of
  // characters and surrogates. Some end on a stray odd byte, some run on into
  // the next stream without an end marker, and a few are pure byte noise.
  task automatic send_random_stream();
    int n;
    bit with_end;
    n = $urandom_range(1, 10);
    with_end = ($urandom_range(0, 6) != 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat (2 * n + $urandom_range(0, 1)) append_byte(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 1)) push_unit(MARK_UNIT);
      repeat (n) push_random_unit();
      if ($urandom_range(0, 5) == 0) append_byte(8'($urandom_range(0, 255)));
    end
    send_stream(with_end);
  endtask

  initial begin : stimulus
    bit hold_done;
    bit drain_done;
    hold_done = 0;
    drain_done = 0;
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A leading mark is dropped; the same bytes again are U+FEFF.
    push_unit(MARK_UNIT);
    push_unit(MARK_UNIT);
    // Smallest unit, first two-byte character, largest unit.
    push_unit(16'h0000);
    push_unit(16'h0080);
    push_unit(16'hFFFF);
    // Largest surrogate pair, U+10FFFF.
    push_unit(HIGH_SURR_LAST);
    push_unit(LOW_SURR_LAST);
    // A high surrogate followed by another one: the first goes out alone,
    // the second pairs with the low surrogate after it.
    push_unit(HIGH_SURR_FIRST);
    push_unit(HIGH_SURR_FIRST);
    push_unit(LOW_SURR_FIRST);
    // Lone low surrogate, then a high surrogate flushed by the end of stream.
    push_unit(LOW_SURR_FIRST);
    push_unit(16'hD834);
    send_stream(1'b1);
    // A stream of one odd byte: the byte is dropped and nothing comes out.
    append_byte(8'h41);
    send_stream(1'b1);

    // Random part, with one long receiver hold-off and one full drain.
    while (items_sent < ITEMS_TARGET) begin
      if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
        hold_done = 1;
        hold_request = 1;
      end
      if (!drain_done && items_sent >= DRAIN_AT_ITEM) begin
        drain_done = 1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.owed_count() != 0) @(posedge clk);
      end
      send_random_stream();
    end

    in_valid <= 1'b0;
    while (board.owed_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.owed_count() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
